### hw/rtl/hsr_pkg.sv
// shared constants, codes and word types of the handle slot registry
`timescale 1ns / 1ps
package hsr_pkg;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = SLOT_W + 1;
  localparam int unsigned FREED_W = 11;
  localparam logic [FREED_W-1:0] FREED_MAX = '1;

  localparam logic [1:0] OP_CREATE      = 2'd0;
  localparam logic [1:0] OP_LOOKUP      = 2'd1;
  localparam logic [1:0] OP_DESTROY     = 2'd2;
  localparam logic [1:0] OP_DESTROY_ALL = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] owner_id;
    logic [31:0] target_id;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [31:0] param_word;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        result_id;
    logic [31:0]        result_owner;
    logic [15:0]        result_w;
    logic [15:0]        result_h;
    logic [31:0]        result_param;
    logic [FREED_W-1:0] freed_count;
  } rsp_t;

  typedef struct packed {
    logic        active;
    logic [31:0] ident;
    logic [31:0] owner;
  } slot_t;

  typedef struct packed {
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [31:0] param;
  } body_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic [SLOT_W-1:0] addr;
    logic              cmp_vld;
    logic [SLOT_W-1:0] cmp_idx;
  } cmd_t;

endpackage

### hw/rtl/handle_slot_registry.sv
// handle slot registry: every command scans the whole slot table once, one slot a cycle
// result: done_o rises in the done state that follows the scan and is high for one cycle
// a new command is taken only in idle, once the last one has given its result word; busy is high until then
// reset: a clearing pass zeroes every slot of the slot table; busy stays high meanwhile
// the identifier counter restarts at one; the receiver cannot stall the result word
`timescale 1ns / 1ps
module handle_slot_registry (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hsr_pkg::req_t req_i,
  output logic          done_o,
  output hsr_pkg::rsp_t rsp_o
);
  import hsr_pkg::*;

  cmd_t cmd;

  hsr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  hsr_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted word did not start a scan");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a command");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == STATUS_OK || rsp_o.status == STATUS_FULL ||
                rsp_o.status == STATUS_NOT_FOUND)) else $error("illegal status code");

  a_no_scan_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.cmp_vld && !cmd.clear) else $error("load during scan or clear");

endmodule

### hw/rtl/hsr_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module hsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/hsr_ctrl.sv
// controller: clearing pass, table scan sequencing and result strobe
`timescale 1ns / 1ps
module hsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output hsr_pkg::cmd_t cmd_o
);
  import hsr_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0] cmp_idx_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q == CNT_W'(SLOTS)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmp_vld_d = (state_q == S_SCAN) && (cnt_q != CNT_W'(SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cnt_q[SLOT_W-1:0];
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign cmd_o.load    = (state_q == S_IDLE) && start;
  assign cmd_o.clear   = (state_q == S_CLEAR);
  assign cmd_o.addr    = cnt_q[SLOT_W-1:0];
  assign cmd_o.cmp_vld = cmp_vld_q;
  assign cmd_o.cmp_idx = cmp_idx_q;

endmodule

### hw/rtl/hsr_dpath.sv
// datapath: slot tables, per-entry match, identifier counter and result registers
`timescale 1ns / 1ps
module hsr_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsr_pkg::cmd_t cmd_i,
  input  hsr_pkg::req_t req_i,
  output hsr_pkg::rsp_t rsp_o
);
  import hsr_pkg::*;

  req_t               req_q;
  logic               hit_q;
  logic [31:0]        id_cnt_q;
  logic [31:0]        res_id_q;
  logic [31:0]        res_owner_q;
  logic [15:0]        res_w_q;
  logic [15:0]        res_h_q;
  logic [31:0]        res_param_q;
  logic [FREED_W-1:0] freed_q;

  slot_t             slot_rd, slot_wdata;
  body_t             body_rd, body_wdata;
  logic              slot_we, body_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic              cand, first;

  hsr_ram #(.Width($bits(slot_t)), .Depth(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (cmd_i.addr),
    .rdata_o (slot_rd)
  );

  hsr_ram #(.Width($bits(body_t)), .Depth(SLOTS)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (body_we),
    .waddr_i (cmd_i.cmp_idx),
    .wdata_i (body_wdata),
    .raddr_i (cmd_i.addr),
    .rdata_o (body_rd)
  );

  always_comb begin
    case (req_q.op)
      OP_CREATE:  cand = !slot_rd.active;
      OP_LOOKUP,
      OP_DESTROY: cand = slot_rd.active && (slot_rd.ident == req_q.target_id);
      default:    cand = slot_rd.active && (slot_rd.owner == req_q.owner_id);
    endcase
  end

  assign first = cmd_i.cmp_vld && cand && !hit_q;

  assign body_wdata = '{size_w: req_q.size_w, size_h: req_q.size_h,
                        param: req_q.param_word};

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cmd_i.cmp_idx;
    slot_wdata = '0;
    body_we    = 1'b0;
    if (cmd_i.clear) begin
      slot_we    = 1'b1;
      slot_waddr = cmd_i.addr;
    end else if (cmd_i.cmp_vld) begin
      case (req_q.op)
        OP_CREATE: begin
          slot_we    = first;
          body_we    = first;
          slot_wdata = '{active: 1'b1, ident: id_cnt_q, owner: req_q.owner_id};
        end
        OP_DESTROY:     slot_we = first;
        OP_DESTROY_ALL: slot_we = cand;
        default:        slot_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      id_cnt_q <= 32'd1;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.cmp_vld && cand) begin
      hit_q <= 1'b1;
      if (first && (req_q.op == OP_CREATE)) begin
        id_cnt_q <= id_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_i;
      res_id_q    <= '0;
      res_owner_q <= '0;
      res_w_q     <= '0;
      res_h_q     <= '0;
      res_param_q <= '0;
      freed_q     <= '0;
    end else if (cmd_i.cmp_vld && cand) begin
      case (req_q.op)
        OP_CREATE: begin
          if (first) begin
            res_id_q <= id_cnt_q;
          end
        end
        OP_LOOKUP: begin
          if (first) begin
            res_owner_q <= slot_rd.owner;
            res_w_q     <= body_rd.size_w;
            res_h_q     <= body_rd.size_h;
            res_param_q <= body_rd.param;
          end
        end
        OP_DESTROY_ALL: begin
          if (freed_q != FREED_MAX) begin
            freed_q <= freed_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp_o.status = STATUS_OK;
    if (!hit_q) begin
      if (req_q.op == OP_CREATE) begin
        rsp_o.status = STATUS_FULL;
      end else if (req_q.op inside {OP_LOOKUP, OP_DESTROY}) begin
        rsp_o.status = STATUS_NOT_FOUND;
      end
    end
    rsp_o.result_id    = res_id_q;
    rsp_o.result_owner = res_owner_q;
    rsp_o.result_w     = res_w_q;
    rsp_o.result_h     = res_h_q;
    rsp_o.result_param = res_param_q;
    rsp_o.freed_count  = freed_q;
  end

endmodule

### bench/tb_top.sv
// self-checking bench for the handle slot registry: directed, table-full and random command traffic
`timescale 1ns / 1ps
module tb_top;
  import hsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int unsigned SETTLE_TICKS = SLOTS + 8;
  localparam int unsigned OWNER_POOL   = 6;
  localparam int unsigned RANDOM_WORDS = 560;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  req_t req_i;
  rsp_t rsp_o;

  // predicted contents of the slot table
  logic        tbl_active [SLOTS];
  logic [31:0] tbl_ident  [SLOTS];
  logic [31:0] tbl_owner  [SLOTS];
  logic [15:0] tbl_w      [SLOTS];
  logic [15:0] tbl_h      [SLOTS];
  logic [31:0] tbl_param  [SLOTS];
  logic [31:0] next_ident;
  int unsigned live_count;
  int unsigned peak_live;

  rsp_t        pending_words[$];
  rsp_t        due_word;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned refused_count;
  int unsigned cycle_count;

  handle_slot_registry i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int find_ident_slot(input logic [31:0] ident);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_active[i] && tbl_ident[i] == ident) return i;
    end
    return -1;
  endfunction

  function automatic void release_slot(input int i);
    tbl_active[i] = 1'b0;
    tbl_ident[i]  = '0;
    tbl_owner[i]  = '0;
    live_count--;
  endfunction

  function automatic rsp_t registry_apply(input req_t r);
    rsp_t               word;
    int                 hit;
    logic [FREED_W-1:0] freed;
    word  = '0;
    hit   = -1;
    freed = '0;
    case (r.op)
      OP_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_active[i] && hit < 0) hit = i;
        end
        if (hit < 0) begin
          word.status = STATUS_FULL;
          refused_count++;
        end else begin
          tbl_active[hit] = 1'b1;
          tbl_ident[hit]  = next_ident;
          tbl_owner[hit]  = r.owner_id;
          tbl_w[hit]      = r.size_w;
          tbl_h[hit]      = r.size_h;
          tbl_param[hit]  = r.param_word;
          word.result_id  = next_ident;
          next_ident      = next_ident + 32'd1;
          live_count++;
          if (live_count > peak_live) peak_live = live_count;
        end
      end
      OP_LOOKUP: begin
        hit = find_ident_slot(r.target_id);
        if (hit < 0) begin
          word.status = STATUS_NOT_FOUND;
        end else begin
          word.result_owner = tbl_owner[hit];
          word.result_w     = tbl_w[hit];
          word.result_h     = tbl_h[hit];
          word.result_param = tbl_param[hit];
        end
      end
      OP_DESTROY: begin
        hit = find_ident_slot(r.target_id);
        if (hit < 0) word.status = STATUS_NOT_FOUND;
        else release_slot(hit);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i] && tbl_owner[i] == r.owner_id) begin
            release_slot(i);
            if (freed != FREED_MAX) freed = freed + 1'b1;
          end
        end
        word.freed_count = freed;
      end
    endcase
    return word;
  endfunction

  function automatic logic [31:0] pick_live_ident();
    int unsigned base;
    base = $urandom_range(0, SLOTS - 1);
    for (int unsigned k = 0; k < SLOTS; k++) begin
      if (tbl_active[(base + k) % SLOTS]) return tbl_ident[(base + k) % SLOTS];
    end
    return $urandom();
  endfunction

  // eager words go out back to back; the others draw a gap, sometimes counted from idle
  task automatic issue(input logic [1:0] op, input logic [31:0] owner, input logic [31:0] target,
                       input logic [15:0] w, input logic [15:0] h, input logic [31:0] param,
                       input bit eager);
    int unsigned gap;
    req_t        r;
    r.op         = op;
    r.owner_id   = owner;
    r.target_id  = target;
    r.size_w     = w;
    r.size_h     = h;
    r.param_word = param;
    gap = eager ? 0 : $urandom_range(0, 17);
    if (!eager && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_words.push_back(registry_apply(r));
    sent_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    issue(OP_LOOKUP, $urandom(), 32'h0000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_LOOKUP, $urandom(), 32'h0000_0001, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY, $urandom(), 32'hffff_ffff, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY_ALL, 32'h0, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_CREATE, 32'h0, $urandom(), 16'h0000, 16'h0000, 32'h0, 1'b0);
    issue(OP_CREATE, 32'hffff_ffff, $urandom(), 16'hffff, 16'hffff, 32'hffff_ffff, 1'b0);
    issue(OP_CREATE, 32'h0000_5a5a, $urandom(), 16'h8000, 16'h0001, 32'h8000_0001, 1'b0);
    for (int unsigned id = 1; id <= 3; id++) begin
      issue(OP_LOOKUP, $urandom(), id, $urandom(), $urandom(), $urandom(), 1'b0);
    end
    issue(OP_LOOKUP, $urandom(), 32'h0000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_LOOKUP, $urandom(), 32'hffff_ffff, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY, $urandom(), 32'd2, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_LOOKUP, $urandom(), 32'd2, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY, $urandom(), 32'd2, $urandom(), $urandom(), $urandom(), 1'b0);
    // freed slot in the middle is taken first
    issue(OP_CREATE, 32'h0000_5a5a, $urandom(), 16'h1234, 16'h4321, 32'h7fff_fffe, 1'b0);
    issue(OP_LOOKUP, $urandom(), 32'd4, $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_CREATE, 32'hffff_ffff, $urandom(), 16'h0001, 16'h8000, 32'h0000_ffff, 1'b0);
    wait_drained();
    issue(OP_DESTROY_ALL, 32'h0000_5a5a, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY_ALL, 32'h0000_5a5a, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY_ALL, 32'hffff_ffff, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_DESTROY_ALL, 32'h0, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    issue(OP_LOOKUP, $urandom(), 32'd1, $urandom(), $urandom(), $urandom(), 1'b0);
  endtask

  task automatic test_table_full();
    logic [31:0] fill_owner;
    fill_owner = $urandom();
    while (live_count < SLOTS) begin
      issue(OP_CREATE, fill_owner, $urandom(), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom(), 1'b1);
    end
    repeat (3) begin
      issue(OP_CREATE, $urandom(), $urandom(), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom(), 1'b0);
    end
    repeat (4) begin
      issue(OP_LOOKUP, $urandom(), pick_live_ident(), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom(), 1'b0);
    end
    issue(OP_LOOKUP, $urandom(), tbl_ident[SLOTS-1], $urandom_range(0, 65535),
          $urandom_range(0, 65535), $urandom(), 1'b0);
    issue(OP_DESTROY, $urandom(), tbl_ident[$urandom_range(1, SLOTS - 2)],
          $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom(), 1'b0);
    issue(OP_CREATE, fill_owner, $urandom(), $urandom_range(0, 65535),
          $urandom_range(0, 65535), $urandom(), 1'b0);
    issue(OP_CREATE, fill_owner, $urandom(), $urandom_range(0, 65535),
          $urandom_range(0, 65535), $urandom(), 1'b0);
    // one owner holds every slot, so the count reaches its top bit
    issue(OP_DESTROY_ALL, fill_owner, $urandom(), $urandom_range(0, 65535),
          $urandom_range(0, 65535), $urandom(), 1'b0);
    issue(OP_LOOKUP, $urandom(), pick_live_ident(), $urandom_range(0, 65535),
          $urandom_range(0, 65535), $urandom(), 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n_words);
    logic [31:0] pool [OWNER_POOL];
    logic [1:0]  op;
    logic [31:0] owner;
    logic [31:0] target;
    int unsigned pick;
    pool[0] = 32'h0;
    pool[1] = 32'hffff_ffff;
    for (int unsigned p = 2; p < OWNER_POOL; p++) pool[p] = $urandom();
    for (int unsigned n = 0; n < n_words; n++) begin
      pick  = $urandom_range(0, 99);
      owner = ($urandom_range(0, 7) == 0) ? $urandom() : pool[$urandom_range(0, OWNER_POOL - 1)];
      case ($urandom_range(0, 9))
        0: target = $urandom();
        1: target = next_ident - $urandom_range(1, 40);
        default: target = pick_live_ident();
      endcase
      if (pick < 40) op = OP_CREATE;
      else if (pick < 70) op = OP_LOOKUP;
      else if (pick < 90) op = OP_DESTROY;
      else op = OP_DESTROY_ALL;
      if (n % 97 == 96) wait_drained();
      issue(op, owner, target, $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom(),
            (n % 150) < 20);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, rsp_o);
        error_count++;
      end else begin
        due_word = pending_words.pop_front();
        check_field("status", due_word.status, rsp_o.status);
        check_field("result_id", due_word.result_id, rsp_o.result_id);
        check_field("result_owner", due_word.result_owner, rsp_o.result_owner);
        check_field("result_w", due_word.result_w, rsp_o.result_w);
        check_field("result_h", due_word.result_h, rsp_o.result_h);
        check_field("result_param", due_word.result_param, rsp_o.result_param);
        check_field("freed_count", due_word.freed_count, rsp_o.freed_count);
        checked_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    cycle_count   = 0;
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    refused_count = 0;
    live_count    = 0;
    peak_live     = 0;
    next_ident    = 32'd1;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_active[i] = 1'b0;
      tbl_ident[i]  = '0;
      tbl_owner[i]  = '0;
      tbl_w[i]      = '0;
      tbl_h[i]      = '0;
      tbl_param[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_table_full();
    test_random_traffic(RANDOM_WORDS);
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_words.size());
      error_count++;
    end
    $display("%0d commands sent, %0d result words checked, %0d mismatches", sent_count,
             checked_count, error_count);
    $display("table filled to %0d slots, %0d creates refused as full", peak_live, refused_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
